// File: src/segt_pkg.sv
// Shared types and constants for the segment tree point-add / range-sum block.
package segt_pkg;

   localparam int LEAVES_DEFAULT = 1024;

   localparam int POS_W   = 10;
   localparam int VAL_W   = 64;
   localparam int LEFT_W  = 10;
   localparam int RIGHT_W = 11;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic clear;     // zero one memory entry, advance clear counter
      logic load;      // capture the accepted request
      logic add_rd;    // read node k
      logic add_wr;    // write node k += amount, step k to parent
      logic q_lo;      // read node lo, lo++
      logic q_hi;      // hi--, read node hi
      logic q_shift;   // lo >>= 1, hi >>= 1
      logic out_load;  // copy accumulator to result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic lo_lt_hi;
      logic lo_odd;
      logic hi_odd;
      logic k_root;
   } status_type;

endpackage

// File: src/segt_ctrl.sv
// Controller state machine for the segment tree block.
module segt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  segt_pkg::status_type  status,
   output segt_pkg::cmd_type     cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_ADD_RD  = 7'b0000100,
      ST_ADD_WR  = 7'b0001000,
      ST_Q_STEP  = 7'b0010000,
      ST_Q_DRAIN = 7'b0100000,
      ST_Q_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_opcode == segt_pkg::OP_QUERY) ? ST_Q_STEP : ST_ADD_RD;
            end
         end
         ST_ADD_RD: begin
            cmd.add_rd = 1'b1;
            state_in   = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            cmd.add_wr = 1'b1;
            state_in   = status.k_root ? ST_IDLE : ST_ADD_RD;
         end
         ST_Q_STEP: begin
            priority if (!status.lo_lt_hi) begin
               state_in = ST_Q_DRAIN;
            end else if (status.lo_odd) begin
               cmd.q_lo = 1'b1;
            end else if (status.hi_odd) begin
               cmd.q_hi = 1'b1;
            end else begin
               cmd.q_shift = 1'b1;
            end
         end
         ST_Q_DRAIN: begin
            // the last read has already reached the accumulator here
            state_in = ST_Q_OUT;
         end
         ST_Q_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/segt_datapath.sv
// Datapath: node memory, index registers, accumulator and result register.
module segt_datapath #(
   parameter int LEAVES = segt_pkg::LEAVES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  segt_pkg::cmd_type                   cmd,
   output segt_pkg::status_type                status,
   input  logic        [segt_pkg::POS_W-1:0]   req_position,
   input  logic signed [segt_pkg::VAL_W-1:0]   req_add_value,
   input  logic        [segt_pkg::LEFT_W-1:0]  req_range_left,
   input  logic        [segt_pkg::RIGHT_W-1:0] req_range_right,
   output logic signed [segt_pkg::VAL_W-1:0]   rsp_range_sum
);

   localparam int DEPTH  = 2 * LEAVES;
   localparam int NODE_W = $clog2(DEPTH);
   localparam int IDX_W  = NODE_W + 1;
   localparam logic [31:0] LEAVES32  = 32'(LEAVES);
   localparam logic [31:0] LAST_LEAF = 32'(LEAVES - 1);

   logic [segt_pkg::VAL_W-1:0] mem [DEPTH];
   logic [segt_pkg::VAL_W-1:0] mem_q_ff;

   logic [NODE_W-1:0]          k_ff, clr_ff;
   logic [IDX_W-1:0]           lo_ff, hi_ff;
   logic [segt_pkg::VAL_W-1:0] amount_ff, acc_ff, sum_ff;
   logic                       pend_ff;

   logic [31:0]       pos_ext, left_ext, right_ext;
   logic [31:0]       pos_sat, left_sat, right_sat;
   logic [31:0]       k_load32, lo_load32, hi_load32;
   logic [IDX_W-1:0]  hi_m1;
   logic [NODE_W-1:0] rd_addr, wr_addr;
   logic              wr_en;
   logic              rd_en;
   logic [segt_pkg::VAL_W-1:0] wr_data;

   // request decode: saturate bounds, map to node indexes
   always_comb begin
      pos_ext   = {{(32 - segt_pkg::POS_W){1'b0}}, req_position};
      left_ext  = {{(32 - segt_pkg::LEFT_W){1'b0}}, req_range_left};
      right_ext = {{(32 - segt_pkg::RIGHT_W){1'b0}}, req_range_right};
      pos_sat   = (pos_ext > LAST_LEAF) ? LAST_LEAF : pos_ext;
      left_sat  = (left_ext > LEAVES32) ? LEAVES32 : left_ext;
      right_sat = (right_ext > LEAVES32) ? LEAVES32 : right_ext;
      k_load32  = pos_sat + LEAVES32;
      lo_load32 = left_sat + LEAVES32;
      hi_load32 = right_sat + LEAVES32;
   end

   assign hi_m1 = hi_ff - IDX_W'(1);

   always_comb begin
      if (cmd.q_lo) begin
         rd_addr = lo_ff[NODE_W-1:0];
      end else if (cmd.q_hi) begin
         rd_addr = hi_m1[NODE_W-1:0];
      end else begin
         rd_addr = k_ff;
      end
      rd_en   = cmd.add_rd | cmd.q_lo | cmd.q_hi;
      wr_en   = cmd.clear | cmd.add_wr;
      wr_addr = cmd.clear ? clr_ff : k_ff;
      wr_data = cmd.clear ? '0 : (mem_q_ff + amount_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_ff <= clr_ff + NODE_W'(1);
         end
         pend_ff <= cmd.q_lo | cmd.q_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         k_ff      <= k_load32[NODE_W-1:0];
         lo_ff     <= lo_load32[IDX_W-1:0];
         hi_ff     <= hi_load32[IDX_W-1:0];
         amount_ff <= req_add_value;
         acc_ff    <= '0;
      end else begin
         if (cmd.add_wr) begin
            k_ff <= k_ff >> 1;
         end
         if (cmd.q_lo) begin
            lo_ff <= lo_ff + IDX_W'(1);
         end
         if (cmd.q_hi) begin
            hi_ff <= hi_m1;
         end
         if (cmd.q_shift) begin
            lo_ff <= lo_ff >> 1;
            hi_ff <= hi_ff >> 1;
         end
         if (pend_ff) begin
            acc_ff <= acc_ff + mem_q_ff;
         end
      end
      if (cmd.out_load) begin
         sum_ff <= acc_ff;
      end
   end

   always_comb begin
      status.clear_last = &clr_ff;
      status.lo_lt_hi   = lo_ff < hi_ff;
      status.lo_odd     = lo_ff[0];
      status.hi_odd     = hi_ff[0];
      status.k_root     = k_ff == NODE_W'(1);
   end

   assign rsp_range_sum = sum_ff;

endmodule

// File: src/segment_tree_point_add_range_sum.sv
// Top level: segment tree, point add and half-open range sum over LEAVES 64-bit leaves.
// Add: accept, then a read and a write for each tree level, leaf up to root.
// Query: accept, then one node read or index shift per step, and to finish a bound
//   compare, a drain and the post; an empty range goes straight to the finish.
// One item at a time; a finished query waits before posting while the last result is unread.
// Reset (synchronous, active high) then clears the node memory, with req_ready low.
module segment_tree_point_add_range_sum #(
   parameter int LEAVES = segt_pkg::LEAVES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic        [segt_pkg::POS_W-1:0]   req_position,
   input  logic signed [segt_pkg::VAL_W-1:0]   req_add_value,
   input  logic        [segt_pkg::LEFT_W-1:0]  req_range_left,
   input  logic        [segt_pkg::RIGHT_W-1:0] req_range_right,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [segt_pkg::VAL_W-1:0]   rsp_range_sum
);

   // Controller sequences adds (walk leaf to root, adding the amount to each
   // node, which keeps every parent equal to the sum of its children) and
   // queries (bottom-up walk of the two range bounds, at most one node read per step).
   segt_pkg::cmd_type    cmd;
   segt_pkg::status_type status;

   segt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath holds the node memory (registered read), the bound and node
   // index registers, the accumulator and the result register that lets a
   // finished result wait for its transfer while the next item is taken.
   segt_datapath #(
      .LEAVES (LEAVES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_position    (req_position),
      .req_add_value   (req_add_value),
      .req_range_left  (req_range_left),
      .req_range_right (req_range_right),
      .rsp_range_sum   (rsp_range_sum)
   );

endmodule
